[rtl/core/multi_channel_fifo_buffer_unit_macros.svh]
// Assertion macros shared by the multi-channel FIFO buffer RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef MULTI_CHANNEL_FIFO_BUFFER_UNIT_MACROS_SVH
`define MULTI_CHANNEL_FIFO_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCFB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCFB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mcfb_pkg.sv]
// Package for the multi-channel FIFO buffer: field widths, codes, defaults and types.
// Depends on nothing; the interfaces and every RTL module import it.
`default_nettype none

package mcfb_pkg;

    // Default sizes of the store.
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int DATA_WIDTH_DEF   = 32;

    // Fixed payload field widths.
    localparam int OP_W      = 2;
    localparam int CH_W      = 3;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_CH_W   = 4;
    localparam int CFG_LIM_W  = 5;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_IDX_CHANNELS = 2'd0;
    localparam cfg_idx_t CFG_IDX_LIMIT    = 2'd1;

    localparam logic [CFG_CH_W-1:0]  CHANNELS_RESET = 4'd8;
    localparam logic [CFG_LIM_W-1:0] LIMIT_RESET    = 5'd16;

    // Operation codes; the unused code behaves as a peek.
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_PUSH = 2'd0;
    localparam op_t OP_POP  = 2'd1;
    localparam op_t OP_PEEK = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DESC,
        S_DATA
    } state_t;

    // Access strobes for one synchronous memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

[rtl/core/mcfb_intf.sv]
// Handshake interfaces of the multi-channel FIFO buffer: request, response, configuration.
// Depends on mcfb_pkg for the field widths.
`default_nettype none

interface mcfb_req_if
    import mcfb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [CH_W-1:0]   channel;
    logic [WORD_W-1:0] write_data;

    modport source (output valid, output op, output channel, output write_data,
                    input ready);
    modport sink   (input valid, input op, input channel, input write_data,
                    output ready);
endinterface

interface mcfb_rsp_if
    import mcfb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   read_data;
    logic [OCC_W-1:0]    occupancy;
    logic                queue_full;
    logic                queue_empty;
    logic                all_idle;

    modport source (output valid, output status, output read_data, output occupancy,
                    output queue_full, output queue_empty, output all_idle,
                    input ready);
    modport sink   (input valid, input status, input read_data, input occupancy,
                    input queue_full, input queue_empty, input all_idle,
                    output ready);
endinterface

interface mcfb_cfg_if
    import mcfb_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/mcfb_desc_store.sv]
// Queue descriptor memory: head, tail and count of each channel, one word per channel.
// Depends on mcfb_pkg; entries read as zero until first written.
`default_nettype none

module mcfb_desc_store
    import mcfb_pkg::*;
#(
    parameter int DEPTH = MAX_CHANNELS_DEF,
    parameter int WIDTH = 13,
    parameter int AW    = 3
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mem_ctl_t         ctl,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    logic [DEPTH-1:0] written_reg;
    logic             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    // One written flag per descriptor stands in for the reset value of zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                written_reg[addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rvalid_reg <= written_reg[addr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

[rtl/core/mcfb_entry_store.sv]
// Shared entry store holding the words of every channel queue.
// Depends on mcfb_pkg; contents are undefined until written.
`default_nettype none

module mcfb_entry_store
    import mcfb_pkg::*;
#(
    parameter int DEPTH = MAX_CHANNELS_DEF * QUEUE_DEPTH_DEF,
    parameter int WIDTH = DATA_WIDTH_DEF,
    parameter int AW    = 7
)
(
    input  wire logic             clk,
    input  wire mem_ctl_t         ctl,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/mcfb_ctrl.sv]
// Sequencer of the multi-channel FIFO buffer: configuration registers, descriptor
// read-modify-write, entry store access and the response register.
// Depends on mcfb_pkg, the interfaces and the assertion macros.
`default_nettype none
`include "multi_channel_fifo_buffer_unit_macros.svh"

module mcfb_ctrl
    import mcfb_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
    parameter int PTR_W        = 4,
    parameter int CNT_W        = 5,
    parameter int CH_AW        = 3,
    parameter int EA_W         = 7
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    mcfb_req_if.sink                         req,
    mcfb_rsp_if.source                       rsp,
    mcfb_cfg_if.sink                         cfg,
    output mem_ctl_t                         desc_ctl,
    output logic     [CH_AW-1:0]             desc_addr,
    output logic     [2*PTR_W+CNT_W-1:0]     desc_wdata,
    input  wire logic [2*PTR_W+CNT_W-1:0]    desc_rdata,
    output mem_ctl_t                         entry_ctl,
    output logic     [EA_W-1:0]              entry_addr,
    output logic     [DATA_WIDTH-1:0]        entry_wdata,
    input  wire logic [DATA_WIDTH-1:0]       entry_rdata
);

    localparam int NCW_RAW = $clog2(MAX_CHANNELS + 1);
    localparam int NCW     = (NCW_RAW > CFG_CH_W) ? NCW_RAW : CFG_CH_W;
    localparam int LMW     = (CNT_W > CFG_LIM_W) ? CNT_W : CFG_LIM_W;

    state_t                 state_reg, state_next;
    op_t                    op_reg;
    logic [CH_W-1:0]        ch_reg;
    logic [WORD_W-1:0]      wd_reg;
    logic [CFG_CH_W-1:0]    cfg_ch_reg;
    logic [CFG_LIM_W-1:0]   cfg_lim_reg;
    status_t                status_reg, status_next;
    logic [CNT_W-1:0]       occ_reg, occ_next;
    logic                   full_reg, full_next;
    logic                   empty_reg, empty_next;
    logic                   use_rd_reg, use_rd_next;
    logic [MAX_CHANNELS-1:0] nonempty_reg;

    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg;
    logic [WORD_W-1:0]      out_data_reg;
    logic [OCC_W-1:0]       out_occ_reg;
    logic                   out_full_reg, out_empty_reg, out_idle_reg;

    logic                   req_accept;
    logic                   out_load;
    logic                   in_range;
    logic                   idle_now;
    logic [PTR_W-1:0]       head, tail, head_new, tail_new;
    logic [CNT_W-1:0]       cnt;
    logic [LMW-1:0]         lim;
    logic [EA_W-1:0]        ch_base;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] q;
        q = {1'b0, p} + (PTR_W+1)'(1);
        if (q >= (PTR_W+1)'(QUEUE_DEPTH))
        begin
            return '0;
        end
        return q[PTR_W-1:0];
    endfunction

    assign req.ready  = (state_reg == S_IDLE);
    assign req_accept = req.valid && req.ready;
    assign cfg.ready  = 1'b1;

    assign head = desc_rdata[2*PTR_W+CNT_W-1 -: PTR_W];
    assign tail = desc_rdata[PTR_W+CNT_W-1 -: PTR_W];
    assign cnt  = desc_rdata[CNT_W-1:0];

    assign in_range = (NCW'(ch_reg) < NCW'(cfg_ch_reg)) && (NCW'(ch_reg) < NCW'(MAX_CHANNELS));
    assign lim      = (LMW'(cfg_lim_reg) > LMW'(QUEUE_DEPTH)) ? LMW'(QUEUE_DEPTH)
                                                               : LMW'(cfg_lim_reg);
    assign ch_base  = EA_W'(ch_reg) * EA_W'(QUEUE_DEPTH);
    assign out_load = (state_reg == S_DATA) && (!out_valid_reg || rsp.ready);

    // Only enabled channels take part in the idle summary.
    always_comb
    begin
        idle_now = 1'b1;
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            if ((NCW'(i) < NCW'(cfg_ch_reg)) && nonempty_reg[i])
            begin
                idle_now = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        desc_ctl    = '0;
        entry_ctl   = '0;
        desc_addr   = CH_AW'(req.channel);
        entry_addr  = ch_base + EA_W'(tail);
        entry_wdata = DATA_WIDTH'(wd_reg);
        head_new    = head;
        tail_new    = tail;
        occ_next    = cnt;
        status_next = ST_DONE;
        use_rd_next = 1'b0;
        full_next   = 1'b0;
        empty_next  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    desc_ctl.rd_en = (NCW'(req.channel) < NCW'(MAX_CHANNELS));
                    state_next     = S_DESC;
                end
            end
            S_DESC:
            begin
                desc_addr = CH_AW'(ch_reg);
                priority if (!in_range)
                begin
                    status_next = ST_RANGE;
                    occ_next    = '0;
                end
                else if (op_reg == OP_PUSH)
                begin
                    if (LMW'(cnt) >= lim || LMW'(cnt) >= LMW'(QUEUE_DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        entry_ctl.wr_en = 1'b1;
                        desc_ctl.wr_en  = 1'b1;
                        tail_new        = advance(tail);
                        occ_next        = cnt + CNT_W'(1);
                    end
                end
                else
                begin
                    entry_addr = ch_base + EA_W'(head);
                    if (cnt == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        entry_ctl.rd_en = 1'b1;
                        use_rd_next     = 1'b1;
                        if (op_reg == OP_POP)
                        begin
                            desc_ctl.wr_en = 1'b1;
                            head_new       = advance(head);
                            occ_next       = cnt - CNT_W'(1);
                        end
                    end
                end
                if (in_range)
                begin
                    full_next  = (LMW'(occ_next) >= lim);
                    empty_next = (occ_next == '0);
                end
                state_next = S_DATA;
            end
            S_DATA:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        desc_wdata = {head_new, tail_new, occ_next};

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cfg_ch_reg    <= CHANNELS_RESET;
            cfg_lim_reg   <= LIMIT_RESET;
            nonempty_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_IDX_CHANNELS: cfg_ch_reg  <= cfg.data[CFG_CH_W-1:0];
                    CFG_IDX_LIMIT:    cfg_lim_reg <= cfg.data[CFG_LIM_W-1:0];
                    default:          ;
                endcase
            end
            if (desc_ctl.wr_en)
            begin
                nonempty_reg[CH_AW'(ch_reg)] <= (occ_next != '0);
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            op_reg <= req.op;
            ch_reg <= req.channel;
            wd_reg <= req.write_data;
        end
        if (state_reg == S_DESC)
        begin
            status_reg <= status_next;
            occ_reg    <= occ_next;
            full_reg   <= full_next;
            empty_reg  <= empty_next;
            use_rd_reg <= use_rd_next;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_data_reg   <= use_rd_reg ? WORD_W'(entry_rdata) : '0;
            out_occ_reg    <= OCC_W'(occ_reg);
            out_full_reg   <= full_reg;
            out_empty_reg  <= empty_reg;
            out_idle_reg   <= idle_now;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.read_data   = out_data_reg;
    assign rsp.occupancy   = out_occ_reg;
    assign rsp.queue_full  = out_full_reg;
    assign rsp.queue_empty = out_empty_reg;
    assign rsp.all_idle    = out_idle_reg;

    `MCFB_ASSERT_NXT(a_accept_starts_lookup, clk, rst_n, req_accept,
        state_reg == S_DESC, "accepted request did not start a descriptor lookup")
    `MCFB_ASSERT_IMP(a_refusal_keeps_state, clk, rst_n,
        state_reg == S_DESC && status_next != ST_DONE,
        !desc_ctl.wr_en && !entry_ctl.wr_en, "refused request modified queue state")
    `MCFB_ASSERT_IMP(a_store_write_is_push, clk, rst_n, entry_ctl.wr_en,
        state_reg == S_DESC && op_reg == OP_PUSH && in_range, "entry written outside a push")
    `MCFB_ASSERT_IMP(a_count_bounded, clk, rst_n, desc_ctl.wr_en,
        LMW'(occ_next) <= LMW'(QUEUE_DEPTH), "queue count exceeds the store depth")
    `MCFB_ASSERT_IMP(a_result_from_engine, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg == S_DATA), "response raised without a finished request")

endmodule

`default_nettype wire

[rtl/core/multi_channel_fifo_buffer_unit.sv]
// Multi-channel FIFO buffer: up to MAX_CHANNELS independent queues of QUEUE_DEPTH words
// sharing one entry store, each capped by a configurable entry limit. Each request
// pushes, pops or peeks the queue named by its channel and yields exactly one response
// with status, the word read, the occupancy, full and empty flags and an all-idle flag.
// One request is worked on at a time, from the cycle of its transfer up to the loading
// of the response register: a descriptor memory read, a descriptor write-back with the
// entry store access, and the entry store read data. A new request is accepted in the
// cycle after its predecessor's response is loaded, so no request overlaps the last one,
// and the response register load waits while the response side does not keep up.
// Configuration writes are taken in any cycle and must only occur while the buffer is idle.
// Depends on mcfb_pkg, the interfaces, mcfb_ctrl, mcfb_desc_store and mcfb_entry_store.
`default_nettype none

module multi_channel_fifo_buffer_unit
    import mcfb_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mcfb_req_if.sink   req,
    mcfb_rsp_if.source rsp,
    mcfb_cfg_if.sink   cfg
);

    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int CH_AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int STORE_N  = MAX_CHANNELS * QUEUE_DEPTH;
    localparam int EA_W     = (STORE_N > 1) ? $clog2(STORE_N) : 1;
    localparam int DESC_W   = 2 * PTR_W + CNT_W;

    mem_ctl_t                desc_ctl;
    logic [CH_AW-1:0]        desc_addr;
    logic [DESC_W-1:0]       desc_wdata;
    logic [DESC_W-1:0]       desc_rdata;
    mem_ctl_t                entry_ctl;
    logic [EA_W-1:0]         entry_addr;
    logic [DATA_WIDTH-1:0]   entry_wdata;
    logic [DATA_WIDTH-1:0]   entry_rdata;

    mcfb_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .DATA_WIDTH   (DATA_WIDTH),
        .PTR_W        (PTR_W),
        .CNT_W        (CNT_W),
        .CH_AW        (CH_AW),
        .EA_W         (EA_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .desc_ctl    (desc_ctl),
        .desc_addr   (desc_addr),
        .desc_wdata  (desc_wdata),
        .desc_rdata  (desc_rdata),
        .entry_ctl   (entry_ctl),
        .entry_addr  (entry_addr),
        .entry_wdata (entry_wdata),
        .entry_rdata (entry_rdata)
    );

    mcfb_desc_store #(
        .DEPTH (MAX_CHANNELS),
        .WIDTH (DESC_W),
        .AW    (CH_AW)
    ) u_desc_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (desc_ctl),
        .addr  (desc_addr),
        .wdata (desc_wdata),
        .rdata (desc_rdata)
    );

    mcfb_entry_store #(
        .DEPTH (STORE_N),
        .WIDTH (DATA_WIDTH),
        .AW    (EA_W)
    ) u_entry_store (
        .clk   (clk),
        .ctl   (entry_ctl),
        .addr  (entry_addr),
        .wdata (entry_wdata),
        .rdata (entry_rdata)
    );

endmodule

`default_nettype wire

[dv/tb_multi_channel_fifo_buffer_unit.sv]
// Self-checking testbench for multi_channel_fifo_buffer_unit: directed and random push, pop
// and peek traffic checked against a queue-level predictor of every response field.
// Depends on mcfb_pkg, the handshake interfaces in mcfb_intf.sv and the buffer RTL.

module tb_multi_channel_fifo_buffer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import mcfb_pkg::*;

    localparam int NUM_QUEUES   = MAX_CHANNELS_DEF;
    localparam int QUEUE_SLOTS  = QUEUE_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    // The spare operation code is not named in the package; it acts as a peek.
    localparam op_t OP_SPARE = 2'd3;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] read_data;
        logic [OCC_W-1:0]  occupancy;
        logic              full;
        logic              empty;
        logic              idle;
    } fifo_response_t;

    logic clk;
    logic rst_n;

    mcfb_req_if req_bus ();
    mcfb_rsp_if rsp_bus ();
    mcfb_cfg_if cfg_bus ();

    multi_channel_fifo_buffer_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // Mirror of the queues and of the two configuration registers.
    logic [WORD_W-1:0]    mirror_store [NUM_QUEUES][QUEUE_SLOTS];
    int unsigned          mirror_head  [NUM_QUEUES];
    int unsigned          mirror_tail  [NUM_QUEUES];
    int unsigned          mirror_count [NUM_QUEUES];
    logic [CFG_CH_W-1:0]  mirror_channels;
    logic [CFG_LIM_W-1:0] mirror_limit;

    fifo_response_t pending_responses [$];

    bit no_idle;
    int hold_off_cycles;
    int cycle_count;
    int requests_sent;
    int responses_checked;
    int settings_applied;
    int fault_count;
    int status_tally [4];

    always #2 clk = ~clk;

    function automatic int unsigned enabled_queues();
        return (mirror_channels > NUM_QUEUES) ? NUM_QUEUES : mirror_channels;
    endfunction

    function automatic fifo_response_t compute_fifo_response(input op_t op,
                                                             input logic [CH_W-1:0] ch,
                                                             input logic [WORD_W-1:0] word);
        fifo_response_t r;
        int unsigned    live;
        int unsigned    cap;
        r        = '0;
        r.status = ST_DONE;
        live     = enabled_queues();
        cap      = (mirror_limit > QUEUE_SLOTS) ? QUEUE_SLOTS : mirror_limit;
        if (ch >= live)
        begin
            r.status = ST_RANGE;
        end
        else
        begin
            if (op == OP_PUSH)
            begin
                if (mirror_count[ch] >= cap || mirror_count[ch] >= QUEUE_SLOTS)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    mirror_store[ch][mirror_tail[ch]] = word;
                    mirror_tail[ch] = (mirror_tail[ch] + 1) % QUEUE_SLOTS;
                    mirror_count[ch]++;
                end
            end
            else if (mirror_count[ch] == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.read_data = mirror_store[ch][mirror_head[ch]];
                if (op == OP_POP)
                begin
                    mirror_head[ch] = (mirror_head[ch] + 1) % QUEUE_SLOTS;
                    mirror_count[ch]--;
                end
            end
            r.occupancy = OCC_W'(mirror_count[ch]);
            r.full      = (mirror_count[ch] >= cap);
            r.empty     = (mirror_count[ch] == 0);
        end
        // Disabled queues keep their words but are left out of the idle flag.
        r.idle = 1'b1;
        for (int q = 0; q < live; q++)
        begin
            if (mirror_count[q] != 0)
                r.idle = 1'b0;
        end
        return r;
    endfunction

    task automatic send_request(input op_t op, input logic [CH_W-1:0] ch,
                                input logic [WORD_W-1:0] word);
        int gap;
        gap = 0;
        if (!no_idle)
        begin
            while ($urandom_range(99) < 27)
                gap++;
        end
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.op         <= op;
        req_bus.channel    <= ch;
        req_bus.write_data <= word;
        do
            @(posedge clk);
        while (!req_bus.ready);
        pending_responses.push_back(compute_fifo_response(op, ch, word));
        requests_sent++;
    endtask

    // Registers only change once the buffer has drained every outstanding request.
    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        req_bus.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        if (idx == CFG_IDX_CHANNELS)
            mirror_channels = value[CFG_CH_W-1:0];
        else
            mirror_limit = value[CFG_LIM_W-1:0];
        settings_applied++;
    endtask

    task automatic test_basic_access();
        send_request(OP_POP, 3'd0, $urandom);
        send_request(OP_PEEK, 3'd7, $urandom);
        send_request(OP_PUSH, 3'd0, 32'h0000_0000);
        send_request(OP_PUSH, 3'd0, 32'hFFFF_FFFF);
        send_request(OP_PEEK, 3'd0, $urandom);
        send_request(OP_SPARE, 3'd0, $urandom);
        send_request(OP_POP, 3'd0, $urandom);
        send_request(OP_PUSH, 3'd7, 32'hA5A5_5A5A);
    endtask

    task automatic test_channel_enable();
        // Channel 7 still holds a word while it is switched off.
        write_register(CFG_IDX_CHANNELS, 5'd2);
        send_request(OP_POP, 3'd7, $urandom);
        send_request(OP_POP, 3'd0, $urandom);
        write_register(CFG_IDX_CHANNELS, 5'd0);
        send_request(OP_PUSH, 3'd0, $urandom);
        // All ones saturates to the full set of queues.
        write_register(CFG_IDX_CHANNELS, 5'd31);
        send_request(OP_PEEK, 3'd7, $urandom);
    endtask

    task automatic test_entry_limit();
        write_register(CFG_IDX_LIMIT, 5'd1);
        send_request(OP_PUSH, 3'd1, 32'h0000_1234);
        send_request(OP_PUSH, 3'd1, $urandom);
        write_register(CFG_IDX_LIMIT, 5'd0);
        send_request(OP_PUSH, 3'd2, $urandom);
        send_request(OP_POP, 3'd1, $urandom);
        write_register(CFG_IDX_LIMIT, 5'd31);
        repeat (3) send_request(OP_PUSH, 3'd3, $urandom);
        // Lowering the limit below the occupancy refuses pushes but keeps the words.
        write_register(CFG_IDX_LIMIT, 5'd2);
        send_request(OP_PUSH, 3'd3, $urandom);
        send_request(OP_POP, 3'd3, $urandom);
        send_request(OP_POP, 3'd3, $urandom);
        send_request(OP_POP, 3'd7, $urandom);
        send_request(OP_POP, 3'd3, $urandom);
    endtask

    task automatic test_fill_under_backpressure();
        write_register(CFG_IDX_CHANNELS, 5'd8);
        write_register(CFG_IDX_LIMIT, 5'd16);
        hold_off_cycles = 200;
        repeat (QUEUE_SLOTS + 2) send_request(OP_PUSH, 3'd4, $urandom);
        repeat (QUEUE_SLOTS + 1) send_request(OP_POP, 3'd4, $urandom);
    endtask

    // Push-heavy and pop-heavy stretches alternate so that queues both fill and drain.
    task automatic run_traffic_phase(input logic [CFG_DATA_W-1:0] ch_setting,
                                     input logic [CFG_DATA_W-1:0] lim_setting,
                                     input int items);
        int unsigned     live;
        int              push_pct;
        int              pick;
        op_t             op;
        logic [CH_W-1:0] ch;
        write_register(CFG_IDX_CHANNELS, ch_setting);
        write_register(CFG_IDX_LIMIT, lim_setting);
        live     = enabled_queues();
        push_pct = 50;
        for (int n = 0; n < items; n++)
        begin
            if (n % 40 == 0)
                push_pct = ((n / 40) % 2 == 0) ? $urandom_range(85, 60)
                                               : $urandom_range(40, 15);
            if (live > 0 && $urandom_range(99) < 90)
                ch = CH_W'($urandom_range(live - 1));
            else
                ch = CH_W'($urandom_range(NUM_QUEUES - 1));
            pick = $urandom_range(99);
            if (pick < push_pct)
                op = OP_PUSH;
            else if (pick < push_pct + (100 - push_pct) * 7 / 10)
                op = OP_POP;
            else if ($urandom_range(4) != 0)
                op = OP_PEEK;
            else
                op = OP_SPARE;
            send_request(op, ch, $urandom);
        end
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] ch_setting;
        logic [CFG_DATA_W-1:0] lim_setting;
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:
                begin
                    ch_setting  = 5'd8;
                    lim_setting = 5'd16;
                end
                1:
                begin
                    ch_setting  = 5'd1;
                    lim_setting = 5'd1;
                end
                2:
                begin
                    ch_setting  = 5'd8;
                    lim_setting = 5'd1;
                end
                3:
                begin
                    ch_setting  = 5'd1;
                    lim_setting = 5'd16;
                end
                4:
                begin
                    ch_setting  = 5'd15;
                    lim_setting = 5'd31;
                end
                default:
                begin
                    ch_setting  = ($urandom_range(5) == 0)
                                  ? CFG_DATA_W'($urandom_range(31))
                                  : CFG_DATA_W'($urandom_range(8, 1));
                    lim_setting = ($urandom_range(3) == 0)
                                  ? CFG_DATA_W'($urandom_range(31))
                                  : CFG_DATA_W'($urandom_range(16, 1));
                end
            endcase
            // The first phase runs without any idle cycles on either side.
            no_idle = (phase == 0);
            if (phase == 6)
                hold_off_cycles = 150;
            run_traffic_phase(ch_setting, lim_setting, 140);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : response_receiver
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_off_cycles--;
            end
            else if (no_idle)
            begin
                rsp_bus.ready <= 1'b1;
            end
            else
            begin
                rsp_bus.ready <= ($urandom_range(99) >= 27);
            end
        end
    end

    initial
    begin : response_checker
        fifo_response_t seen;
        fifo_response_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
            begin
                seen.status    = status_t'(rsp_bus.status);
                seen.read_data = rsp_bus.read_data;
                seen.occupancy = rsp_bus.occupancy;
                seen.full      = rsp_bus.queue_full;
                seen.empty     = rsp_bus.queue_empty;
                seen.idle      = rsp_bus.all_idle;
                if (pending_responses.size() == 0)
                begin
                    if (fault_count < REPORT_LIMIT)
                        $display("unexpected response: status %0d data %h occupancy %0d",
                                 seen.status, seen.read_data, seen.occupancy);
                    fault_count++;
                end
                else
                begin
                    want = pending_responses.pop_front();
                    status_tally[want.status]++;
                    if (seen !== want)
                    begin
                        if (fault_count < REPORT_LIMIT)
                        begin
                            $display({"response %0d expected: status %0d data %h ",
                                      "occ %0d full %b empty %b idle %b"},
                                     responses_checked, want.status, want.read_data,
                                     want.occupancy, want.full, want.empty, want.idle);
                            $display({"response %0d actual:   status %0d data %h ",
                                      "occ %0d full %b empty %b idle %b"},
                                     responses_checked, seen.status, seen.read_data,
                                     seen.occupancy, seen.full, seen.empty, seen.idle);
                        end
                        fault_count++;
                    end
                end
                responses_checked++;
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d responses outstanding",
                 cycle_count, pending_responses.size());
        $display("multi_channel_fifo_buffer_unit: mismatch");
        $finish;
    end

    initial
    begin : test_sequence
        clk                = 1'b0;
        rst_n              <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.op         <= OP_PUSH;
        req_bus.channel    <= '0;
        req_bus.write_data <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= CFG_IDX_CHANNELS;
        cfg_bus.data       <= '0;
        no_idle            = 1'b0;
        hold_off_cycles    = 0;
        mirror_channels    = CHANNELS_RESET;
        mirror_limit       = LIMIT_RESET;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            mirror_head[q]  = 0;
            mirror_tail[q]  = 0;
            mirror_count[q] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_access();
        test_channel_enable();
        test_entry_limit();
        test_fill_under_backpressure();
        test_random_traffic();

        req_bus.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (2 * DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests under %0d register writes, %0d responses checked",
                 requests_sent, settings_applied, responses_checked);
        $display("outcomes: %0d done, %0d full, %0d empty, %0d out of range",
                 status_tally[ST_DONE], status_tally[ST_FULL], status_tally[ST_EMPTY],
                 status_tally[ST_RANGE]);
        if (fault_count == 0)
            $display("multi_channel_fifo_buffer_unit: match");
        else
            $display("multi_channel_fifo_buffer_unit: mismatch");
        $finish;
    end

endmodule
